[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[hw/rtl/fsc_pkg.sv]
// Package with the shared types and constants of the frustum sphere culler.
package fsc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_SUMSQ,
    ST_SQRT,
    ST_DIV,
    ST_NEXT,
    ST_QRY,
    ST_RES
  } fsc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_col;
    logic       load_qry;
    logic       raw_go;
    logic       sq_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       coef_wr;
    logic       mac_step;
    logic       acc_clr;
    logic [2:0] plane;
    logic [1:0] coef;
    logic [1:0] term;
    logic [5:0] step;
  } fsc_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic sum_zero;
    logic reject;
  } fsc_sts_t;

endpackage

[hw/rtl/fsc_ctrl.sv]
// Controller state machine that sequences plane forming and sphere tests.
module fsc_ctrl #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_func,
  input  fsc_pkg::fsc_sts_t sts,
  output fsc_pkg::fsc_cmd_t cmd,
  output logic              busy,
  output logic              out_valid,
  output logic              first_rej
);
  import fsc_pkg::*;

  // Last divider step: one step per dividend bit, then the coefficient write.
  localparam logic [5:0] DIV_LAST = 6'(32 + FRAC_BITS);

  fsc_state_t state_r, state_nxt;
  logic [2:0] plane_r, plane_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [5:0] step_r, step_nxt;
  logic       rej_r, rej_nxt;

  // Registers of the controller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      plane_r <= '0;
      sub_r   <= '0;
      step_r  <= '0;
      rej_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
      sub_r   <= sub_nxt;
      step_r  <= step_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    sub_nxt   = sub_r;
    step_nxt  = step_r;
    rej_nxt   = rej_r;
    unique case (state_r)
      ST_IDLE: begin
        plane_nxt = '0;
        sub_nxt   = '0;
        step_nxt  = '0;
        rej_nxt   = 1'b0;
        if (start) begin
          state_nxt = in_func ? ST_QRY : ST_RAW;
        end
      end
      ST_RAW: begin
        state_nxt = ST_SUMSQ;
        sub_nxt   = '0;
      end
      ST_SUMSQ: begin
        sub_nxt = sub_r + 2'd1;
        if (sub_r == 2'd2) begin
          state_nxt = ST_SQRT;
          step_nxt  = '0;
        end
      end
      ST_SQRT: begin
        if (sts.sum_zero) begin
          state_nxt = ST_DIV;
          step_nxt  = '0;
          sub_nxt   = '0;
        end else begin
          step_nxt = step_r + 6'd1;
          if (step_r == 6'd32) begin
            state_nxt = ST_DIV;
            step_nxt  = '0;
            sub_nxt   = '0;
          end
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 6'd1;
        if (sts.sum_zero || step_r == DIV_LAST) begin
          step_nxt = '0;
          sub_nxt  = sub_r + 2'd1;
          if (sub_r == 2'd3) begin
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        plane_nxt = plane_r + 3'd1;
        state_nxt = (plane_r == 3'd5) ? ST_IDLE : ST_RAW;
      end
      ST_QRY: begin
        sub_nxt = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          sub_nxt = '0;
          if (step_r[0]) begin
            step_nxt = '0;
            if (sts.reject) rej_nxt = 1'b1;
            plane_nxt = plane_r + 3'd1;
            if (plane_r == 3'd5) state_nxt = ST_RES;
          end else begin
            step_nxt = 6'd1;
            sub_nxt  = 2'd3;
          end
        end
      end
      ST_RES: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd           = '0;
    cmd.plane     = plane_r;
    cmd.coef      = sub_r;
    cmd.term      = sub_r;
    cmd.step      = step_r;
    busy          = (state_r != ST_IDLE);
    out_valid     = (state_r == ST_RES);
    first_rej     = rej_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_col = start && !in_func;
        cmd.load_qry = start && in_func;
      end
      ST_RAW:   cmd.raw_go = 1'b1;
      ST_SUMSQ: begin
        cmd.sq_step   = 1'b1;
        cmd.sqrt_init = (sub_r == 2'd2);
      end
      ST_SQRT: begin
        cmd.sqrt_step = !sts.sum_zero && step_r != 6'd32;
        cmd.div_init  = sts.sum_zero || step_r == 6'd32;
      end
      ST_DIV: begin
        cmd.div_step = !sts.sum_zero && step_r != DIV_LAST;
        cmd.coef_wr  = sts.sum_zero || step_r == DIV_LAST;
        cmd.div_init = cmd.coef_wr;
      end
      ST_QRY: begin
        cmd.mac_step = !(sub_r == 2'd3 && step_r[0]);
        cmd.acc_clr  = (sub_r == 2'd3 && step_r[0]);
      end
      default: ;
    endcase
  end
endmodule

[hw/rtl/fsc_dp.sv]
// Datapath: matrix and plane stores, square root, divider and query MAC.
module fsc_dp #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fsc_pkg::fsc_cmd_t  cmd,
  input  logic [1:0]         in_column_index,
  input  logic signed [31:0] in_col_entry_0,
  input  logic signed [31:0] in_col_entry_1,
  input  logic signed [31:0] in_col_entry_2,
  input  logic signed [31:0] in_col_entry_3,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0]        in_radius,
  output fsc_pkg::fsc_sts_t  sts
);
  import fsc_pkg::*;

  localparam int DW = 33 + FRAC_BITS;  // dividend width

  logic signed [31:0] mat_r [16];
  logic signed [31:0] pl_r  [24];
  logic signed [31:0] raw_r [4];
  logic [31:0]        mag_r [4];
  logic [63:0]        sum_r;
  logic [63:0]        srem_r;
  logic [63:0]        root_r;
  logic [DW-1:0]      drem_r;
  logic [DW-1:0]      quo_r;
  logic signed [31:0] qx_r, qy_r, qz_r;
  logic [30:0]        rad_r;
  logic signed [31:0] mul_a_r, mul_b_r;
  logic signed [63:0] prod_r;
  logic signed [66:0] acc_r;

  // Raw plane coefficient for the current plane and coefficient index.
  function automatic logic signed [31:0] raw_coef(input logic signed [31:0] b,
                                                   input logic signed [31:0] o,
                                                   input logic neg);
    logic signed [32:0] s;
    s = neg ? ({b[31], b} - {o[31], o}) : ({b[31], b} + {o[31], o});
    if (s > 33'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (s < -33'sh080000000) return 32'sh80000000;
    return s[31:0];
  endfunction

  logic [1:0] sel_row;
  logic       sel_neg;
  always_comb begin
    sel_row = cmd.plane[2:1];
    unique case (cmd.plane)
      3'd1, 3'd2, 3'd5: sel_neg = 1'b1;
      default:          sel_neg = 1'b0;
    endcase
  end

  // Square root step values.
  logic [63:0] sbit, strial;
  assign sbit   = 64'd1 << (7'd62 - {cmd.step[4:0], 1'b0});
  assign strial = root_r + sbit;

  // Divider step values, restoring long division of the rounded dividend,
  // most significant bit first.
  logic [DW-1:0] dnum;
  logic [DW:0]   dtrial;
  logic [DW:0]   dlen;
  logic [5:0]    dsh;
  assign dsh    = 6'(DW - 2) - cmd.step;
  assign dnum   = ({{(DW-32){1'b0}}, mag_r[cmd.coef]} << FRAC_BITS)
                  + {{(DW-31){1'b0}}, root_r[31:1]};
  assign dtrial = {drem_r, dnum[dsh]};
  assign dlen   = {{(DW-31){1'b0}}, root_r[31:0]};

  logic [DW-1:0] q_in;
  logic [31:0]   q_sat;
  logic signed [31:0] coef_val;
  always_comb begin
    q_in = quo_r;
    q_sat = (q_in > DW'(32'h80000000)) ? 32'h80000000 : q_in[31:0];
    if (raw_r[cmd.coef] < 0) coef_val = -$signed(q_sat);
    else if (q_sat == 32'h80000000) coef_val = 32'sh7FFFFFFF;
    else coef_val = $signed(q_sat);
    if (sts.sum_zero) coef_val = '0;
  end

  // Matrix and plane stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
      for (int i = 0; i < 24; i++) pl_r[i] <= '0;
    end else begin
      if (cmd.load_col) begin
        mat_r[{in_column_index, 2'd0}] <= in_col_entry_0;
        mat_r[{in_column_index, 2'd1}] <= in_col_entry_1;
        mat_r[{in_column_index, 2'd2}] <= in_col_entry_2;
        mat_r[{in_column_index, 2'd3}] <= in_col_entry_3;
      end
      if (cmd.coef_wr) pl_r[5'(cmd.plane * 4 + cmd.coef)] <= coef_val;
    end
  end

  // Normalization datapath.
  always_ff @(posedge clk) begin
    if (cmd.raw_go) begin
      sum_r <= '0;
      for (int k = 0; k < 4; k++) begin
        raw_r[k] <= raw_coef(mat_r[k*4+3], mat_r[k*4+32'(sel_row)], sel_neg);
        mag_r[k] <= 32'(raw_coef(mat_r[k*4+3], mat_r[k*4+32'(sel_row)], sel_neg) < 0 ?
                    -raw_coef(mat_r[k*4+3], mat_r[k*4+32'(sel_row)], sel_neg) :
                    raw_coef(mat_r[k*4+3], mat_r[k*4+32'(sel_row)], sel_neg));
      end
    end
    if (cmd.sq_step) sum_r <= sum_r + mag_r[cmd.term] * mag_r[cmd.term];
    if (cmd.sqrt_init) begin
      srem_r <= sum_r + mag_r[2] * mag_r[2];
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      if (srem_r >= strial) begin
        srem_r <= srem_r - strial;
        root_r <= (root_r >> 1) + sbit;
      end else begin
        root_r <= root_r >> 1;
      end
    end
    if (cmd.div_init) begin
      drem_r <= '0;
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      if (dtrial >= dlen) begin
        drem_r <= DW'(dtrial - dlen);
        quo_r  <= {quo_r[DW-2:0], 1'b1};
      end else begin
        drem_r <= dtrial[DW-1:0];
        quo_r  <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  // Query multiply-accumulate, one term per cycle while mac_step is high.
  logic signed [31:0] op_a, op_b;
  always_comb begin
    op_a = pl_r[5'(cmd.plane * 4 + cmd.term)];
    unique case (cmd.term)
      2'd0: op_b = qx_r;
      2'd1: op_b = qy_r;
      2'd2: op_b = qz_r;
      default: op_b = 32'sd0;
    endcase
  end

  // Operands are registered, then multiplied; the x product starts the sum
  // of a plane, the y product adds to it and the z product is added at the compare.
  always_ff @(posedge clk) begin
    if (cmd.load_qry) begin
      qx_r <= in_pos_x;
      qy_r <= in_pos_y;
      qz_r <= in_pos_z;
      rad_r <= in_radius;
    end
    if (cmd.mac_step) begin
      mul_a_r <= op_a;
      mul_b_r <= op_b;
      prod_r  <= mul_a_r * mul_b_r;
    end
    if (cmd.load_qry || cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.mac_step && cmd.term == 2'd2) begin
      acc_r <= 67'(prod_r);
    end else if (cmd.mac_step && cmd.term == 2'd3) begin
      acc_r <= acc_r + 67'(prod_r);
    end
  end

  // Final plane compare with the d term and radius.
  logic signed [66:0] dterm, total;
  assign dterm = (67'(pl_r[5'(cmd.plane * 4 + 3)]) + 67'($signed({1'b0, rad_r})))
                 <<< FRAC_BITS;
  assign total = acc_r + 67'(prod_r) + dterm;

  // Status: zero normal and plane rejection.
  assign sts = {(sum_r == 64'd0), (total <= 67'sd0)};
endmodule

[hw/rtl/frustum_sphere_culler.sv]
// Top level of the frustum sphere culler.
// A load (func 0) writes one matrix column and then forms all six clip planes
// again, one plane after another. Each plane goes through the raw coefficients,
// the sum of squares, the bit-serial square root, the restoring divider for each
// coefficient (its division steps and the write) and the move to the next plane;
// a plane with a zero normal skips the root and divider steps and writes zero
// coefficients. A query (func 1) walks the six planes through one shared
// multiplier and puts its result on out_inside_res with out_valid. start is taken
// only while busy is low, and the receiver cannot hold a result off: it stands
// for exactly one cycle.
`include "assert_macros.svh"
module frustum_sphere_culler #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [1:0]         in_column_index,
  input  logic signed [31:0] in_col_entry_0,
  input  logic signed [31:0] in_col_entry_1,
  input  logic signed [31:0] in_col_entry_2,
  input  logic signed [31:0] in_col_entry_3,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0]        in_radius,
  output logic               out_valid,
  output logic               out_inside_res
);
  import fsc_pkg::*;

  fsc_cmd_t cmd;
  fsc_sts_t sts;
  logic     rej;

  // Controller.
  fsc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk, .rst_n, .start, .in_func, .sts, .cmd, .busy, .out_valid,
    .first_rej(rej)
  );

  // Datapath.
  fsc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .in_column_index, .in_col_entry_0, .in_col_entry_1,
    .in_col_entry_2, .in_col_entry_3, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_radius, .sts
  );

  assign out_inside_res = !rej;

  // A result only appears while busy.
  `ASSERT_IMPL(a_res_busy, out_valid, busy, "result outside a transaction")
  // A result ends the transaction.
  `ASSERT_NEXT(a_res_end, out_valid, !busy, "busy after result")
endmodule
